// ===== sv/zfbs_pkg.sv =====
package zfbs_pkg;

    // buffer depth and derived widths
    localparam int MAX_LEN = 1024;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int OUT_W   = 10;
    localparam int BYTE_W  = 8;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);

    // controller states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_ZSTART,
        ST_ZMIN,
        ST_ZRD,
        ST_ZCMP,
        ST_SRD,
        ST_SEVAL,
        ST_PUB
    } t_state;

    // text store access: one write, two reads (two copies)
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
    } t_text_port;

    // z-value store access
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CNT_W-1:0]  wdata;
        logic [ADDR_W-1:0] raddr;
    } t_z_port;

    // positions reported modulo 2**OUT_W
    function automatic logic [OUT_W-1:0] to_out(input logic [CNT_W-1:0] v);
        logic [CNT_W+OUT_W-1:0] wide;
        wide = {{OUT_W{1'b0}}, v};
        return wide[OUT_W-1:0];
    endfunction

endpackage

// ===== sv/zfbs_in_if.sv =====
interface zfbs_in_if;
    import zfbs_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] char_in;
    logic              is_last;

    modport source (output valid, output char_in, output is_last, input ready);
    modport sink   (input valid, input char_in, input is_last, output ready);
endinterface

// ===== sv/zfbs_out_if.sv =====
interface zfbs_out_if;
    import zfbs_pkg::*;

    logic             valid;
    logic             ready;
    logic             found;
    logic [OUT_W-1:0] match_start;
    logic [OUT_W-1:0] match_length;
    logic             overflow;

    modport source (output valid, output found, output match_start,
                    output match_length, output overflow, input ready);
    modport sink   (input valid, input found, input match_start,
                    input match_length, input overflow, output ready);
endinterface

// ===== sv/z_function_border_search.sv =====
// prefix-suffix-middle search over a byte string by Z-array
// i_in carries one byte per request (char_in) and a last marker (is_last);
// o_out carries one result per string: found, match_start, match_length
// and overflow (bytes beyond the buffer depth were dropped).
// loading stores each accepted byte up to the buffer depth; i_in stays ready while bytes load.
// after the last byte the Z pass runs on the stored text if it holds two or
// more bytes: per position it fetches the mirrored z value, clamps it to
// the window, then alternates text reads and compares until a mismatch or
// the end of the text; then the scan reads and checks one z value after
// another until a hit or the end, and the publish state loads the result
// register; all three stores have registered reads.
// i_in is not ready during the search.
// the result register frees the input: a new string may load while the
// previous result waits; a search that ends while the result is still
// stalled holds until o_out.ready takes it.
// reset clears the byte count, the drop flag and the result valid; the
// stores need no clearing since only entries of the current string are read.
module z_function_border_search (
    input  logic            i_clk,
    input  logic            i_rst_n,
    zfbs_in_if.sink         i_in,
    zfbs_out_if.source      o_out
);
    import zfbs_pkg::*;

    t_text_port        text;
    t_z_port           zport;
    logic [BYTE_W-1:0] text_rdata_a;
    logic [BYTE_W-1:0] text_rdata_b;
    logic [CNT_W-1:0]  z_rdata;

    // controller and datapath
    zfbs_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in.valid),
        .o_in_ready     (i_in.ready),
        .i_char_in      (i_in.char_in),
        .i_is_last      (i_in.is_last),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_found        (o_out.found),
        .o_match_start  (o_out.match_start),
        .o_match_length (o_out.match_length),
        .o_overflow     (o_out.overflow),
        .o_text         (text),
        .i_text_rdata_a (text_rdata_a),
        .i_text_rdata_b (text_rdata_b),
        .o_zport        (zport),
        .i_z_rdata      (z_rdata)
    );

    // text store, two copies for two reads per compare
    zfbs_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_LEN)) u_text_a (
        .i_clk   (i_clk),
        .i_we    (text.we),
        .i_waddr (text.waddr),
        .i_wdata (text.wdata),
        .i_raddr (text.raddr_a),
        .o_rdata (text_rdata_a)
    );

    zfbs_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_LEN)) u_text_b (
        .i_clk   (i_clk),
        .i_we    (text.we),
        .i_waddr (text.waddr),
        .i_wdata (text.wdata),
        .i_raddr (text.raddr_b),
        .o_rdata (text_rdata_b)
    );

    // z-value store
    zfbs_ram #(.WIDTH(CNT_W), .DEPTH(MAX_LEN)) u_zval (
        .i_clk   (i_clk),
        .i_we    (zport.we),
        .i_waddr (zport.waddr),
        .i_wdata (zport.wdata),
        .i_raddr (zport.raddr),
        .o_rdata (z_rdata)
    );

    // text is written only by an accepted request
    a_text_we_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        text.we |-> (i_in.valid && i_in.ready))
        else $error("text store written without an accepted request");

    // no match reports zero start and length
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.found) |-> (o_out.match_start == '0 &&
                                           o_out.match_length == '0))
        else $error("missed search reports nonzero position");

    // a match never starts at position zero and has nonzero length
    a_hit_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.found) |-> (o_out.match_start != '0 &&
                                          o_out.match_length != '0))
        else $error("match at position zero or of zero length");
endmodule

// ===== sv/zfbs_ram.sv =====
module zfbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/zfbs_ctrl.sv =====
module zfbs_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [zfbs_pkg::BYTE_W-1:0] i_char_in,
    input  logic                        i_is_last,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_found,
    output logic [zfbs_pkg::OUT_W-1:0]  o_match_start,
    output logic [zfbs_pkg::OUT_W-1:0]  o_match_length,
    output logic                        o_overflow,
    output zfbs_pkg::t_text_port        o_text,
    input  logic [zfbs_pkg::BYTE_W-1:0] i_text_rdata_a,
    input  logic [zfbs_pkg::BYTE_W-1:0] i_text_rdata_b,
    output zfbs_pkg::t_z_port           o_zport,
    input  logic [zfbs_pkg::CNT_W-1:0]  i_z_rdata
);
    import zfbs_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_drop, n_drop;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_l, n_l;
    logic [CNT_W-1:0] r_r, n_r;
    logic [CNT_W-1:0] r_z, n_z;
    logic [CNT_W-1:0] r_best, n_best;
    logic             r_hit, n_hit;
    logic [CNT_W-1:0] r_start, n_start;
    logic [CNT_W-1:0] r_len, n_len;
    logic             r_out_valid, n_out_valid;
    logic             r_found, n_found;
    logic [OUT_W-1:0] r_mstart, n_mstart;
    logic [OUT_W-1:0] r_mlen, n_mlen;
    logic             r_ovf, n_ovf;

    logic [CNT_W:0]   i_plus_z;
    logic [CNT_W:0]   i_plus_zr;
    logic [CNT_W-1:0] r_minus_i;
    logic [CNT_W-1:0] i_minus_l;
    logic [CNT_W-1:0] i_next;
    logic [CNT_W-1:0] n_len_str;
    logic             fin;

    assign i_plus_z  = {1'b0, r_i} + {1'b0, r_z};
    assign i_plus_zr = {1'b0, r_i} + {1'b0, i_z_rdata};
    assign r_minus_i = r_r - r_i;
    assign i_minus_l = r_i - r_l;
    assign i_next    = r_i + CNT_W'(1);
    assign n_len_str = (r_count < MAX_CNT) ? r_count + CNT_W'(1) : r_count;

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
        end
    end

    // working and result payload
    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_l      <= n_l;
        r_r      <= n_r;
        r_z      <= n_z;
        r_best   <= n_best;
        r_hit    <= n_hit;
        r_start  <= n_start;
        r_len    <= n_len;
        r_found  <= n_found;
        r_mstart <= n_mstart;
        r_mlen   <= n_mlen;
        r_ovf    <= n_ovf;
    end

    // next state, store accesses
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_drop      = r_drop;
        n_i         = r_i;
        n_l         = r_l;
        n_r         = r_r;
        n_z         = r_z;
        n_best      = r_best;
        n_hit       = r_hit;
        n_start     = r_start;
        n_len       = r_len;
        n_out_valid = r_out_valid;
        n_found     = r_found;
        n_mstart    = r_mstart;
        n_mlen      = r_mlen;
        n_ovf       = r_ovf;
        fin         = 1'b0;
        o_in_ready  = 1'b0;

        o_text.we      = 1'b0;
        o_text.waddr   = r_count[ADDR_W-1:0];
        o_text.wdata   = i_char_in;
        o_text.raddr_a = i_plus_z[ADDR_W-1:0];
        o_text.raddr_b = r_z[ADDR_W-1:0];
        o_zport.we     = 1'b0;
        o_zport.waddr  = r_i[ADDR_W-1:0];
        o_zport.wdata  = r_z;
        o_zport.raddr  = i_minus_l[ADDR_W-1:0];

        // result taken downstream
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (r_count < MAX_CNT) begin
                        o_text.we = 1'b1;
                        n_count   = r_count + CNT_W'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_is_last) begin
                        // z[0] is defined as zero
                        o_zport.we    = 1'b1;
                        o_zport.waddr = '0;
                        o_zport.wdata = '0;
                        n_l    = '0;
                        n_r    = '0;
                        n_best = '0;
                        n_hit  = 1'b0;
                        if (n_len_str > CNT_W'(1)) begin
                            n_i     = CNT_W'(1);
                            n_state = ST_ZSTART;
                        end else begin
                            n_i     = '0;
                            n_state = ST_SRD;
                        end
                    end
                end
            end
            ST_ZSTART: begin
                // fetch mirrored z value inside the window
                n_state = ST_ZMIN;
            end
            ST_ZMIN: begin
                if (r_i < r_r) begin
                    n_z = (i_z_rdata < r_minus_i) ? i_z_rdata : r_minus_i;
                end else begin
                    n_z = '0;
                end
                n_state = ST_ZRD;
            end
            ST_ZRD: begin
                if (i_plus_z < {1'b0, r_count}) begin
                    n_state = ST_ZCMP;
                end else begin
                    fin = 1'b1;
                end
            end
            ST_ZCMP: begin
                if (i_text_rdata_a == i_text_rdata_b) begin
                    n_z     = r_z + CNT_W'(1);
                    n_state = ST_ZRD;
                end else begin
                    fin = 1'b1;
                end
            end
            ST_SRD: begin
                o_zport.raddr = r_i[ADDR_W-1:0];
                n_state       = ST_SEVAL;
            end
            ST_SEVAL: begin
                if (i_z_rdata != '0 && i_plus_zr == {1'b0, r_count}
                        && i_z_rdata <= r_best) begin
                    n_hit   = 1'b1;
                    n_start = r_i;
                    n_len   = i_z_rdata;
                    n_state = ST_PUB;
                end else begin
                    if (i_z_rdata > r_best) begin
                        n_best = i_z_rdata;
                    end
                    n_i = i_next;
                    if (i_next == r_count) begin
                        n_state = ST_PUB;
                    end else begin
                        n_state = ST_SRD;
                    end
                end
            end
            ST_PUB: begin
                // load result once the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_found     = r_hit;
                    n_mstart    = r_hit ? to_out(r_start) : '0;
                    n_mlen      = r_hit ? to_out(r_len) : '0;
                    n_ovf       = r_drop;
                    n_count     = '0;
                    n_drop      = 1'b0;
                    n_state     = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase

        // position done: store z, move window, advance
        if (fin) begin
            o_zport.we = 1'b1;
            if (i_plus_z > {1'b0, r_r}) begin
                n_l = r_i;
                n_r = i_plus_z[CNT_W-1:0];
            end
            if (i_next == r_count) begin
                n_i     = '0;
                n_state = ST_SRD;
            end else begin
                n_i     = i_next;
                n_state = ST_ZSTART;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_found;
    assign o_match_start  = r_mstart;
    assign o_match_length = r_mlen;
    assign o_overflow     = r_ovf;
endmodule
